// File: design/rxu_pkg.sv
// Shared types, constants and helper functions of the rolled-XOR image unpacker.
package rxu_pkg;

  // Image layout
  localparam int PAGE_BYTES   = 256;
  localparam int SECTOR_BYTES = 512;
  localparam int SIG_LEN      = 10;
  localparam int DATA_START   = 4 * SECTOR_BYTES;
  localparam int HDR_BASE     = DATA_START - 48;

  localparam int HDR_POS_W  = $clog2(DATA_START);
  localparam int PAGE_IDX_W = $clog2(PAGE_BYTES);
  localparam int SIG_IDX_W  = $clog2(SIG_LEN);
  localparam int PAGES_W    = 17;
  localparam int ADDR_W     = 24;
  localparam int SUM_W      = 16;

  localparam logic [PAGES_W-1:0] PAGES_WRAP = PAGES_W'(65536);

  // Header field offsets
  localparam logic [HDR_POS_W-1:0] POS_ADDR_HI  = HDR_POS_W'(HDR_BASE);
  localparam logic [HDR_POS_W-1:0] POS_ADDR_MID = HDR_POS_W'(HDR_BASE + 1);
  localparam logic [HDR_POS_W-1:0] POS_ADDR_LO  = HDR_POS_W'(HDR_BASE + 2);
  localparam logic [HDR_POS_W-1:0] POS_PAGES_HI = HDR_POS_W'(HDR_BASE + 3);
  localparam logic [HDR_POS_W-1:0] POS_PAGES_LO = HDR_POS_W'(HDR_BASE + 4);
  localparam logic [HDR_POS_W-1:0] POS_SIG_LAST = HDR_POS_W'(SIG_LEN - 1);
  localparam logic [HDR_POS_W-1:0] POS_HDR_LAST = HDR_POS_W'(DATA_START - 1);
  localparam logic [PAGE_IDX_W-1:0] IDX_LAST    = PAGE_IDX_W'(PAGE_BYTES - 1);

  // Queue
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Entry kinds
  localparam logic [1:0] KIND_ADDR_HI  = 2'd0;
  localparam logic [1:0] KIND_ADDR_MID = 2'd1;
  localparam logic [1:0] KIND_ADDR_LO  = 2'd2;
  localparam logic [1:0] KIND_DATA     = 2'd3;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic       page_end;
    logic       image_done;
    logic       key_missing;
  } entry_t;

  function automatic logic [7:0] rol1(input logic [7:0] b);
    rol1 = {b[6:0], b[7]};
  endfunction

  // Signature "[settings]"
  function automatic logic [7:0] sig_char(input logic [SIG_IDX_W-1:0] idx);
    case (idx)
      SIG_IDX_W'(0): sig_char = 8'h5B;
      SIG_IDX_W'(1): sig_char = 8'h73;
      SIG_IDX_W'(2): sig_char = 8'h65;
      SIG_IDX_W'(3): sig_char = 8'h74;
      SIG_IDX_W'(4): sig_char = 8'h74;
      SIG_IDX_W'(5): sig_char = 8'h69;
      SIG_IDX_W'(6): sig_char = 8'h6E;
      SIG_IDX_W'(7): sig_char = 8'h67;
      SIG_IDX_W'(8): sig_char = 8'h73;
      SIG_IDX_W'(9): sig_char = 8'h5D;
      default:       sig_char = 8'h00;
    endcase
  endfunction

endpackage

// File: design/rxu_front.sv
// Front end: key recovery, byte decoding, header parsing and page counting.
module rxu_front import rxu_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       file_valid,
  output logic       file_stall,
  input  logic [7:0] file_byte,
  input  logic       q_full,
  output logic       push,
  output entry_t     push_entry
);

  logic [HDR_POS_W-1:0]  hdr_pos;
  logic                  in_data;
  logic [PAGE_IDX_W-1:0] page_idx;
  logic                  plain_match;
  logic                  rolled_match;
  logic [7:0]            rolled_key;
  logic [7:0]            active_key;
  logic                  key_lost;
  logic [7:0]            pages_hi;
  logic [PAGES_W-1:0]    pages_left;
  logic                  finished;

  logic       accept;
  logic       in_sig;
  logic [7:0] rolled;
  logic [7:0] ch;
  logic [7:0] decoded;
  logic       plain_now;
  logic       rolled_now;
  logic       last_in_page;
  logic [PAGES_W-1:0] pages_loaded;

  // Classify the current byte
  always_comb begin
    file_stall   = q_full;
    accept       = file_valid && !q_full;
    in_sig       = !in_data && (hdr_pos < HDR_POS_W'(SIG_LEN));
    rolled       = rol1(file_byte);
    ch           = sig_char(hdr_pos[SIG_IDX_W-1:0]);
    decoded      = (active_key == 8'h00) ? file_byte : (rolled ^ active_key);
    plain_now    = plain_match && (file_byte == ch);
    rolled_now   = rolled_match && ((rolled ^ rolled_key) == ch);
    last_in_page = (page_idx == IDX_LAST);
    pages_loaded = {1'b0, pages_hi, decoded};
    if (pages_loaded == '0) begin
      pages_loaded = PAGES_WRAP;
    end

    push_entry.data        = decoded;
    push_entry.page_end    = last_in_page;
    push_entry.image_done  = last_in_page && (pages_left == PAGES_W'(1));
    push_entry.key_missing = key_lost;
    push_entry.kind        = KIND_DATA;
    push                   = 1'b0;
    if (accept && !finished) begin
      if (in_data) begin
        push = 1'b1;
      end else if (hdr_pos == POS_ADDR_HI) begin
        push            = 1'b1;
        push_entry.kind = KIND_ADDR_HI;
      end else if (hdr_pos == POS_ADDR_MID) begin
        push            = 1'b1;
        push_entry.kind = KIND_ADDR_MID;
      end else if (hdr_pos == POS_ADDR_LO) begin
        push            = 1'b1;
        push_entry.kind = KIND_ADDR_LO;
      end
    end
  end

  // Advance position, key and page state on each accepted beat before the image is finished
  always_ff @(posedge clk) begin
    if (rst) begin
      hdr_pos      <= '0;
      in_data      <= 1'b0;
      page_idx     <= '0;
      plain_match  <= 1'b1;
      rolled_match <= 1'b1;
      rolled_key   <= 8'h00;
      active_key   <= 8'h00;
      key_lost     <= 1'b0;
      pages_hi     <= 8'h00;
      pages_left   <= '0;
      finished     <= 1'b0;
    end else if (accept && !finished) begin
      if (in_data) begin
        if (last_in_page) begin
          page_idx   <= '0;
          pages_left <= pages_left - PAGES_W'(1);
          if (pages_left == PAGES_W'(1)) begin
            finished <= 1'b1;
          end
        end else begin
          page_idx <= page_idx + PAGE_IDX_W'(1);
        end
      end else begin
        hdr_pos <= hdr_pos + HDR_POS_W'(1);
        if (hdr_pos == POS_HDR_LAST) begin
          in_data <= 1'b1;
        end
        if (in_sig) begin
          plain_match <= plain_now;
          if (hdr_pos == '0) begin
            rolled_key   <= rolled ^ ch;
            rolled_match <= ((rolled ^ ch) != 8'h00);
          end else begin
            rolled_match <= rolled_now;
          end
          if (hdr_pos == POS_SIG_LAST) begin
            if (plain_now) begin
              active_key <= 8'h00;
              key_lost   <= 1'b0;
            end else if (rolled_now) begin
              active_key <= rolled_key;
              key_lost   <= 1'b0;
            end else begin
              active_key <= 8'h00;
              key_lost   <= 1'b1;
            end
          end
        end
        if (hdr_pos == POS_PAGES_HI) begin
          pages_hi <= decoded;
        end
        if (hdr_pos == POS_PAGES_LO) begin
          pages_left <= pages_loaded;
        end
      end
    end
  end

endmodule

// File: design/rxu_queue.sv
// Short queue of classified entries between front and back end.
module rxu_queue import rxu_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t push_entry,
  input  logic   pop,
  output entry_t head,
  output logic   not_empty,
  output logic   full
);

  entry_t             slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  count;

  always_comb begin
    head      = slots[rd_ptr];
    not_empty = (count != '0);
    full      = (count == QCNT_W'(QUEUE_DEPTH));
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  // Move pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule

// File: design/rxu_back.sv
// Back end: flash address tracking, running sum and output register.
module rxu_back import rxu_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  entry_t            head,
  input  logic              not_empty,
  output logic              pop,
  output logic              page_valid,
  input  logic              page_stall,
  output logic [7:0]        page_byte,
  output logic [ADDR_W-1:0] flash_address,
  output logic              page_end,
  output logic              image_done,
  output logic [SUM_W-1:0]  running_sum,
  output logic              key_missing
);

  logic [ADDR_W-1:0] next_address;
  logic [SUM_W-1:0]  sum_register;

  logic             slot_free;
  logic             pop_data;
  logic [SUM_W-1:0] sum_next;

  always_comb begin
    slot_free = !page_valid || !page_stall;
    pop       = not_empty && ((head.kind != KIND_DATA) || slot_free);
    pop_data  = pop && (head.kind == KIND_DATA);
    sum_next  = sum_register + SUM_W'(head.data);
  end

  // Hold the beat until taken, load the next one
  always_ff @(posedge clk) begin
    if (rst) begin
      page_valid <= 1'b0;
    end else if (slot_free) begin
      page_valid <= pop_data;
    end
  end

  always_ff @(posedge clk) begin
    if (pop_data) begin
      page_byte     <= head.data;
      flash_address <= next_address;
      page_end      <= head.page_end;
      image_done    <= head.image_done;
      running_sum   <= sum_next;
      key_missing   <= head.key_missing;
    end
  end

  // Update address and sum
  always_ff @(posedge clk) begin
    if (rst) begin
      next_address <= '0;
      sum_register <= '0;
    end else if (pop) begin
      unique case (head.kind)
        KIND_ADDR_HI:  next_address <= {head.data, 16'h0000};
        KIND_ADDR_MID: next_address <= next_address | {8'h00, head.data, 8'h00};
        KIND_ADDR_LO:  next_address <= next_address | {16'h0000, head.data};
        KIND_DATA: begin
          next_address <= next_address + ADDR_W'(1);
          sum_register <= sum_next;
        end
      endcase
    end
  end

endmodule

// File: design/rolled_xor_image_unpacker.sv
// Rolled-XOR image unpacker top level.
//
// Input channel file_valid / file_stall / file_byte carries the raw bytes of an
// update file in file order, one per beat. The first ten bytes select the key,
// bytes 2000 to 2004 give the flash start address and page count, and every
// byte from offset 2048 on leaves as one beat on the output channel
// page_valid / page_stall with its decoded value, flash address, page and image
// end marks, running 16-bit sum and the missing-key flag. Header bytes give
// no output beat; bytes after the last page are taken and dropped.
// Throughput is one byte per cycle on both channels while neither side stalls.
// A data byte taken from the file channel is written into the four-entry queue
// between the decoding front end and the address and sum back end, and from
// there is loaded into the output register that drives page_valid.
// When the receiver stalls, the output beat holds; the queue absorbs up to four
// further bytes, after which file_stall rises until beats drain again.
// Synchronous reset clears key detection, position and page counters, the
// running sum, the queue and the output valid; the next byte is taken as
// the first byte of a new file.
module rolled_xor_image_unpacker import rxu_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              file_valid,
  output logic              file_stall,
  input  logic [7:0]        file_byte,
  output logic              page_valid,
  input  logic              page_stall,
  output logic [7:0]        page_byte,
  output logic [ADDR_W-1:0] flash_address,
  output logic              page_end,
  output logic              image_done,
  output logic [SUM_W-1:0]  running_sum,
  output logic              key_missing
);

  logic   q_full;
  logic   q_not_empty;
  logic   push;
  logic   pop;
  entry_t push_entry;
  entry_t head;

  rxu_front u_front (
    .clk        (clk),
    .rst        (rst),
    .file_valid (file_valid),
    .file_stall (file_stall),
    .file_byte  (file_byte),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  rxu_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .not_empty  (q_not_empty),
    .full       (q_full)
  );

  rxu_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .not_empty     (q_not_empty),
    .pop           (pop),
    .page_valid    (page_valid),
    .page_stall    (page_stall),
    .page_byte     (page_byte),
    .flash_address (flash_address),
    .page_end      (page_end),
    .image_done    (image_done),
    .running_sum   (running_sum),
    .key_missing   (key_missing)
  );

  // The last byte of the image always closes a page
  assert property (@(posedge clk) disable iff (rst)
    page_valid |-> (!image_done || page_end))
    else $error("image_done without page_end");

  // Nothing follows the final beat of the image
  assert property (@(posedge clk) disable iff (rst)
    (page_valid && !page_stall && image_done) |=> !page_valid)
    else $error("beat after image_done");

  // The front end never writes into a full queue
  assert property (@(posedge clk) disable iff (rst)
    push |-> !q_full)
    else $error("queue overflow");

  // The back end never reads an empty queue
  assert property (@(posedge clk) disable iff (rst)
    pop |-> q_not_empty)
    else $error("queue underflow");

endmodule

// File: dv/tb.sv
// Self-checking testbench for the rolled-XOR image unpacker: one whole update file per run.
`timescale 1ns / 100ps

module tb;
  import rxu_pkg::*;

  localparam int WATCHDOG_LIMIT = 500;
  localparam int TAIL_BYTES     = 40;
  localparam int MAX_SENT_PAGES = 5;
  // rotates left onto the first signature character, so the candidate key is zero
  localparam logic [7:0] KEY_ZERO_LEAD = 8'hAD;

  typedef enum {SIG_PLAIN, SIG_ROLLED, SIG_BROKEN, SIG_KEY_ZERO} sig_mode_t;

  typedef struct packed {
    logic [7:0]        data;
    logic [ADDR_W-1:0] addr;
    logic              page_end;
    logic              image_done;
    logic [SUM_W-1:0]  sum;
    logic              key_missing;
  } page_beat_t;

  // Decoder model plus the queue of page beats still owed by the block
  class page_scoreboard;
    localparam logic [8*SIG_LEN-1:0] SIGNATURE = "[settings]";

    page_beat_t        pending_beats[$];
    int unsigned       mismatches;
    logic [24:0]       position;
    logic              plain_ok;
    logic              rolled_ok;
    logic [7:0]        cand_key;
    logic [7:0]        key;
    logic              key_lost;
    logic [ADDR_W-1:0] next_addr;
    logic [16:0]       pages_left;
    logic [SUM_W-1:0]  sum;
    logic              finished;

    function new();
      mismatches = 0;
      position   = '0;
      plain_ok   = 1'b1;
      rolled_ok  = 1'b1;
      cand_key   = '0;
      key        = '0;
      key_lost   = 1'b0;
      next_addr  = '0;
      pages_left = '0;
      sum        = '0;
      finished   = 1'b0;
    endfunction

    static function logic [7:0] sig_byte(int i);
      sig_byte = SIGNATURE[8*(SIG_LEN-1-i) +: 8];
    endfunction

    function logic [7:0] rotl1(logic [7:0] b);
      rotl1 = {b[6:0], b[7]};
    endfunction

    function logic [7:0] unscramble(logic [7:0] b);
      unscramble = (key == 8'h00) ? b : (rotl1(b) ^ key);
    endfunction

    // Advance the model by one accepted file byte
    function void take_file_byte(logic [7:0] b);
      logic [7:0]  ch;
      logic [7:0]  d;
      logic [24:0] idx;
      page_beat_t  beat;
      if (finished) return;
      // signature: pick the key
      if (position < SIG_LEN) begin
        ch = sig_byte(int'(position));
        if (b != ch) plain_ok = 1'b0;
        if (position == 0) begin
          cand_key  = rotl1(b) ^ ch;
          rolled_ok = (cand_key != 8'h00);
        end else if ((rotl1(b) ^ cand_key) != ch) begin
          rolled_ok = 1'b0;
        end
        if (position == SIG_LEN - 1) begin
          if (plain_ok) begin
            key      = 8'h00;
            key_lost = 1'b0;
          end else if (rolled_ok) begin
            key      = cand_key;
            key_lost = 1'b0;
          end else begin
            key      = 8'h00;
            key_lost = 1'b1;
          end
        end
        position++;
        return;
      end
      d = unscramble(b);
      // header: capture address and page count
      if (position < DATA_START) begin
        if (position == HDR_BASE)          next_addr = {d, 16'h0000};
        else if (position == HDR_BASE + 1) next_addr[15:8] = d;
        else if (position == HDR_BASE + 2) next_addr[7:0] = d;
        else if (position == HDR_BASE + 3) pages_left = {1'b0, d, 8'h00};
        else if (position == HDR_BASE + 4) begin
          pages_left[7:0] = d;
          if (pages_left == 0) pages_left = 17'h10000;
        end
        if (position == DATA_START - 1) sum = '0;
        position++;
        return;
      end
      // page data: one beat per byte
      sum += SUM_W'(d);
      idx = position - DATA_START;
      beat.page_end   = 1'b0;
      beat.image_done = 1'b0;
      if (idx >= PAGE_BYTES - 1) begin
        beat.page_end = 1'b1;
        pages_left    = pages_left - 17'd1;
        if (pages_left == 0) begin
          beat.image_done = 1'b1;
          finished        = 1'b1;
        end
        position = DATA_START;
      end else begin
        position++;
      end
      beat.data        = d;
      beat.addr        = next_addr;
      beat.sum         = sum;
      beat.key_missing = key_lost;
      pending_beats.push_back(beat);
      next_addr++;
    endfunction

    task flag_mismatch(string msg);
      $display("mismatch at %0t: %s", $time, msg);
      mismatches++;
    endtask

    // Compare one page beat with the oldest one owed
    task check_beat(page_beat_t got);
      page_beat_t want;
      if (pending_beats.size() == 0) begin
        flag_mismatch($sformatf("unexpected beat byte %02h addr %06h", got.data, got.addr));
        return;
      end
      want = pending_beats.pop_front();
      if (got.data !== want.data)
        flag_mismatch($sformatf("page_byte %02h, want %02h", got.data, want.data));
      if (got.addr !== want.addr)
        flag_mismatch($sformatf("flash_address %06h, want %06h", got.addr, want.addr));
      if (got.page_end !== want.page_end)
        flag_mismatch($sformatf("page_end %b, want %b", got.page_end, want.page_end));
      if (got.image_done !== want.image_done)
        flag_mismatch($sformatf("image_done %b, want %b", got.image_done, want.image_done));
      if (got.sum !== want.sum)
        flag_mismatch($sformatf("running_sum %04h, want %04h", got.sum, want.sum));
      if (got.key_missing !== want.key_missing)
        flag_mismatch($sformatf("key_missing %b, want %b", got.key_missing, want.key_missing));
    endtask
  endclass

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              file_valid = 1'b0;
  logic              file_stall;
  logic [7:0]        file_byte = 8'h00;
  logic              page_valid;
  logic              page_stall = 1'b0;
  logic [7:0]        page_byte;
  logic [ADDR_W-1:0] flash_address;
  logic              page_end;
  logic              image_done;
  logic [SUM_W-1:0]  running_sum;
  logic              key_missing;

  page_scoreboard sb;
  int             src_idle_pct  = 0;
  int             sink_idle_pct = 0;
  int             idle_cycles   = 0;

  rolled_xor_image_unpacker i_dut (
    .clk          (clk),
    .rst          (rst),
    .file_valid   (file_valid),
    .file_stall   (file_stall),
    .file_byte    (file_byte),
    .page_valid   (page_valid),
    .page_stall   (page_stall),
    .page_byte    (page_byte),
    .flash_address(flash_address),
    .page_end     (page_end),
    .image_done   (image_done),
    .running_sum  (running_sum),
    .key_missing  (key_missing)
  );

  always #6 clk = ~clk;

  // Scramble a decoded byte so that the block recovers it under key k
  function automatic logic [7:0] obfuscate(logic [7:0] d, logic [7:0] k);
    logic [7:0] x;
    x = d ^ k;
    obfuscate = (k == 8'h00) ? d : {x[0], x[7:1]};
  endfunction

  // Offer one file byte, with random gaps, and hold it until taken
  task automatic send_byte(logic [7:0] b);
    while ($urandom_range(99) < src_idle_pct) begin
      file_valid <= 1'b0;
      @(posedge clk);
    end
    file_valid <= 1'b1;
    file_byte  <= b;
    @(posedge clk);
    while (file_stall) @(posedge clk);
    sb.take_file_byte(b);
  endtask

  // Check page beats as they are taken, then pick the next stall
  always @(posedge clk) begin
    if (!rst && page_valid && !page_stall)
      sb.check_beat({page_byte, flash_address, page_end, image_done, running_sum, key_missing});
    page_stall <= ($urandom_range(99) < sink_idle_pct);
  end

  // Abort when neither channel moves for too long
  always @(posedge clk) begin
    if (rst || (file_valid && !file_stall) || (page_valid && !page_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("tb failed");
        $finish;
      end
    end
  end

  initial begin
    sig_mode_t         mode;
    logic [7:0]        run_key;
    logic [7:0]        sig_key;
    logic [7:0]        hdr_key;
    logic [7:0]        b;
    logic [ADDR_W-1:0] start_addr;
    logic [15:0]       page_count;
    logic [7:0]        hdr_field [7];
    int                eff_pages;
    int                sent_pages;
    int                total;
    int                corrupt_at;
    int                phase;
    int                r;

    sb = new();

    // Reset clears the decoder for good, so each run carries one file with one key outcome
    r = $urandom_range(99);
    mode = (r < 25) ? SIG_PLAIN : (r < 70) ? SIG_ROLLED : (r < 85) ? SIG_BROKEN : SIG_KEY_ZERO;
    run_key    = 8'($urandom_range(1, 255));
    sig_key    = $urandom_range(1) ? run_key : 8'h00;
    corrupt_at = $urandom_range(SIG_LEN - 1);
    hdr_key    = (mode == SIG_ROLLED) ? run_key : 8'h00;

    case ($urandom_range(3))
      0: start_addr = ADDR_W'($urandom());
      1: start_addr = 24'hFFFF00 | ADDR_W'($urandom_range(255));
      2: start_addr = 24'h000000;
      default: start_addr = 24'hFFFFFF;
    endcase

    // Mostly short images; a zero count means the full wrap count
    r = $urandom_range(9);
    if (r <= 4)      page_count = 16'($urandom_range(1, 3));
    else if (r == 5) page_count = 16'd4;
    else if (r == 6) page_count = 16'd5;
    else if (r == 7) page_count = 16'd0;
    else if (r == 8) page_count = 16'hFFFF;
    else             page_count = 16'($urandom_range(6, 1000));
    eff_pages  = (page_count == 0) ? 65536 : int'(page_count);
    sent_pages = (eff_pages < MAX_SENT_PAGES) ? eff_pages : MAX_SENT_PAGES;
    total      = DATA_START + sent_pages * PAGE_BYTES
                 + ((eff_pages <= MAX_SENT_PAGES) ? TAIL_BYTES : 0);

    hdr_field[0] = start_addr[23:16];
    hdr_field[1] = start_addr[15:8];
    hdr_field[2] = start_addr[7:0];
    hdr_field[3] = page_count[15:8];
    hdr_field[4] = page_count[7:0];
    hdr_field[5] = 8'($urandom_range(255));
    hdr_field[6] = 8'($urandom_range(255));

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < total; i++) begin
      // receiver gaps first, then sender gaps, then none, over thirds of the page data
      if (i < DATA_START) phase = 0;
      else phase = ((i - DATA_START) * 3) / (total - DATA_START);
      case (phase)
        0: begin
          src_idle_pct  = 14;
          sink_idle_pct = 69;
        end
        1: begin
          src_idle_pct  = 69;
          sink_idle_pct = 14;
        end
        default: begin
          src_idle_pct  = 0;
          sink_idle_pct = 0;
        end
      endcase
      if (i < SIG_LEN) begin
        case (mode)
          SIG_PLAIN:  b = page_scoreboard::sig_byte(i);
          SIG_ROLLED: b = obfuscate(page_scoreboard::sig_byte(i), run_key);
          SIG_BROKEN: begin
            b = obfuscate(page_scoreboard::sig_byte(i), sig_key);
            if (i == corrupt_at) b = b ^ (8'h01 << $urandom_range(7));
          end
          default: b = (i == 0) ? KEY_ZERO_LEAD : page_scoreboard::sig_byte(i);
        endcase
      end else if (i >= HDR_BASE && i < HDR_BASE + 7) begin
        b = obfuscate(hdr_field[i - HDR_BASE], hdr_key);
      end else if ($urandom_range(15) == 0) begin
        b = $urandom_range(1) ? 8'hFF : 8'h00;
      end else begin
        b = 8'($urandom_range(255));
      end
      send_byte(b);
    end
    file_valid <= 1'b0;

    // Drain owed beats, then watch for strays
    while (sb.pending_beats.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (sb.mismatches == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
